// ----- design/hpt_pkg.sv -----
`default_nettype none
package hpt_pkg;

	localparam int FRAC_BITS_DEF  = 16;
	localparam int WORD_WIDTH_DEF = 32;
	localparam int DATA_W         = 32;
	localparam int IN_TDATA_W     = 168;
	localparam int OUT_TDATA_W    = 128;

	typedef enum logic [1:0] {
		CMD_LOAD   = 2'd0,
		CMD_POINT  = 2'd1,
		CMD_WPOINT = 2'd2,
		CMD_VECTOR = 2'd3
	} cmd_t;

	typedef struct packed {
		logic is_point;
		logic derr;
		logic ovf;
	} ctl_t;

endpackage
`default_nettype wire

// ----- design/hpt_mac.sv -----
`default_nettype none
module hpt_mac import hpt_pkg::*; #(
	parameter int FRAC_BITS  = FRAC_BITS_DEF,
	parameter int WORD_WIDTH = WORD_WIDTH_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         en,
	input  wire logic                         in_valid,
	input  wire cmd_t                         cmd,
	input  wire logic [1:0]                   row_index,
	input  wire logic [1:0]                   col_index,
	input  wire logic signed [DATA_W-1:0]     element_value,
	input  wire logic signed [DATA_W-1:0]     in_x,
	input  wire logic signed [DATA_W-1:0]     in_y,
	input  wire logic signed [DATA_W-1:0]     in_z,
	input  wire logic signed [DATA_W-1:0]     in_w,
	output logic                              valid_s3,
	output ctl_t                              ctl_s3,
	output logic signed [WORD_WIDTH-1:0]      res_s3 [4]
);

	localparam int PW = 2 * DATA_W;
	localparam int SW = PW + 2;
	localparam logic signed [SW-1:0] SAT_HI =
		{{(SW - WORD_WIDTH + 1){1'b0}}, {(WORD_WIDTH - 1){1'b1}}};
	localparam logic signed [SW-1:0] SAT_LO = ~SAT_HI;

	logic signed [DATA_W-1:0] mat_q [16];
	logic signed [DATA_W-1:0] opnd [4];

	logic signed [PW-1:0] prod_s1 [4][4];
	cmd_t                 cmd_s1;
	logic                 valid_s1;
	logic signed [SW-1:0] sum_d [4];
	logic signed [SW-1:0] sum_s2 [4];
	cmd_t                 cmd_s2;
	logic                 valid_s2;
	logic signed [WORD_WIDTH-1:0] res_d [4];
	ctl_t                 ctl_d;

	always_comb begin
		opnd[0] = in_x;
		opnd[1] = in_y;
		opnd[2] = in_z;
		case (cmd)
			CMD_POINT:  opnd[3] = DATA_W'(1) << FRAC_BITS;
			CMD_WPOINT: opnd[3] = in_w;
			default:    opnd[3] = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 16; i++) begin
				mat_q[i] <= (i / 4 == i % 4) ? (DATA_W'(1) << FRAC_BITS) : '0;
			end
		end else if (in_valid && cmd == CMD_LOAD) begin
			mat_q[{row_index, col_index}] <= element_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid && cmd != CMD_LOAD;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_comb begin
		for (int r = 0; r < 4; r++) begin
			sum_d[r] = '0;
			for (int c = 0; c < 4; c++) begin
				sum_d[r] = sum_d[r] + SW'(prod_s1[r][c] >>> FRAC_BITS);
			end
		end
	end

	always_comb begin
		ctl_d.ovf = 1'b0;
		for (int r = 0; r < 4; r++) begin
			if (sum_s2[r] > SAT_HI) begin
				res_d[r]  = {1'b0, {(WORD_WIDTH - 1){1'b1}}};
				ctl_d.ovf = 1'b1;
			end else if (sum_s2[r] < SAT_LO) begin
				res_d[r]  = {1'b1, {(WORD_WIDTH - 1){1'b0}}};
				ctl_d.ovf = 1'b1;
			end else begin
				res_d[r] = sum_s2[r][WORD_WIDTH-1:0];
			end
		end
		if (cmd_s2 == CMD_VECTOR) begin
			res_d[3] = '0;
		end
		ctl_d.is_point = cmd_s2 == CMD_POINT;
		ctl_d.derr     = cmd_s2 == CMD_POINT && res_d[3] == '0;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 4; r++) begin
				for (int c = 0; c < 4; c++) begin
					prod_s1[r][c] <= mat_q[r * 4 + c] * opnd[c];
				end
			end
			cmd_s1 <= cmd;
			sum_s2 <= sum_d;
			cmd_s2 <= cmd_s1;
			res_s3 <= res_d;
			ctl_s3 <= ctl_d;
		end
	end

endmodule
`default_nettype wire

// ----- design/hpt_div.sv -----
`default_nettype none
module hpt_div import hpt_pkg::*; #(
	parameter int FRAC_BITS  = FRAC_BITS_DEF,
	parameter int WORD_WIDTH = WORD_WIDTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          en,
	input  wire logic                          valid_in,
	input  wire ctl_t                          ctl_in,
	input  wire logic signed [WORD_WIDTH-1:0]  res_in [4],
	output logic                               valid_out,
	output logic                               derr_out,
	output logic                               ovf_out,
	output logic signed [WORD_WIDTH-1:0]       res_out [4]
);

	localparam int W  = WORD_WIDTH;
	localparam int DW = 2 * W + FRAC_BITS;
	localparam int NS = W + 2;
	localparam logic [W:0]   HALF  = {2'b01, {(W - 1){1'b0}}};
	localparam logic [W-1:0] W_MAX = {1'b0, {(W - 1){1'b1}}};
	localparam logic [W-1:0] W_MIN = {1'b1, {(W - 1){1'b0}}};

	logic [DW-1:0]        rem_s [NS][3];
	logic [W:0]           quo_s [NS][3];
	logic [2:0]           neg_s [NS];
	logic [W-1:0]         den_s [NS];
	logic signed [W-1:0]  res_s [NS][4];
	ctl_t                 ctl_s [NS];
	logic                 vld_s [NS];

	logic [W-1:0] num_abs [3];
	logic [W-1:0] den_abs;

	always_comb begin
		den_abs = res_in[3][W-1] ? -res_in[3] : res_in[3];
		for (int l = 0; l < 3; l++) begin
			num_abs[l] = res_in[l][W-1] ? -res_in[l] : res_in[l];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 3; l++) begin
				rem_s[0][l] <= DW'(num_abs[l]) << FRAC_BITS;
				quo_s[0][l] <= '0;
				neg_s[0][l] <= res_in[l][W-1] ^ res_in[3][W-1];
			end
			den_s[0] <= den_abs;
			res_s[0] <= res_in;
			ctl_s[0] <= ctl_in;
		end
	end

	for (genvar j = 1; j < NS; j++) begin : g_step
		localparam int K = NS - 1 - j;
		logic [DW-1:0] dsh;
		logic [DW-1:0] rem_d [3];
		logic [W:0]    quo_d [3];

		always_comb begin
			dsh = DW'(den_s[j-1]) << K;
			for (int l = 0; l < 3; l++) begin
				if (rem_s[j-1][l] >= dsh) begin
					rem_d[l] = rem_s[j-1][l] - dsh;
					quo_d[l] = {quo_s[j-1][l][W-1:0], 1'b1};
				end else begin
					rem_d[l] = rem_s[j-1][l];
					quo_d[l] = {quo_s[j-1][l][W-1:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j] <= 1'b0;
			end else if (en) begin
				vld_s[j] <= vld_s[j-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j] <= rem_d;
				quo_s[j] <= quo_d;
				neg_s[j] <= neg_s[j-1];
				den_s[j] <= den_s[j-1];
				res_s[j] <= res_s[j-1];
				ctl_s[j] <= ctl_s[j-1];
			end
		end
	end

	logic [W-1:0]        dv [3];
	logic [2:0]          dovf;
	logic signed [W-1:0] fin_d [4];
	logic                derr_d;
	logic                ovf_d;

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			dovf[l] = 1'b0;
			if (quo_s[NS-1][l] > HALF || (quo_s[NS-1][l] == HALF && !neg_s[NS-1][l])) begin
				dv[l]   = neg_s[NS-1][l] ? W_MIN : W_MAX;
				dovf[l] = 1'b1;
			end else if (neg_s[NS-1][l]) begin
				dv[l] = -quo_s[NS-1][l][W-1:0];
			end else begin
				dv[l] = quo_s[NS-1][l][W-1:0];
			end
		end
		fin_d  = res_s[NS-1];
		derr_d = 1'b0;
		ovf_d  = ctl_s[NS-1].ovf;
		if (ctl_s[NS-1].is_point) begin
			if (ctl_s[NS-1].derr) begin
				derr_d = 1'b1;
				ovf_d  = 1'b0;
				for (int r = 0; r < 4; r++) begin
					fin_d[r] = '0;
				end
			end else begin
				for (int l = 0; l < 3; l++) begin
					fin_d[l] = dv[l];
				end
				ovf_d = ctl_s[NS-1].ovf | (|dovf);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_out <= 1'b0;
		end else if (en) begin
			valid_out <= vld_s[NS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_out  <= fin_d;
			derr_out <= derr_d;
			ovf_out  <= ovf_d;
		end
	end

endmodule
`default_nettype wire

// ----- design/homogeneous_point_transform.sv -----
// Throughput: one transaction per cycle while m_tready is high or the output is empty;
// the quotient pipeline resolves one bit per stage, and all stages stall otherwise.
// Loads update the matrix at acceptance and produce no result.
// Reset: asynchronous, active low; matrix returns to identity, pipeline empties.
`default_nettype none
module homogeneous_point_transform import hpt_pkg::*; #(
	parameter int FRAC_BITS  = FRAC_BITS_DEF,
	parameter int WORD_WIDTH = WORD_WIDTH_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	// row_index, col_index, element_value, in_x, in_y, in_z, in_w
	input  wire logic [IN_TDATA_W-1:0]  s_tdata,
	// command
	input  wire logic [1:0]             s_tuser,
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	// out_x, out_y, out_z, out_w
	output logic [OUT_TDATA_W-1:0]      m_tdata,
	// divide_error, overflow
	output logic [1:0]                  m_tuser
);

	logic                         en;
	logic                         valid_s3;
	ctl_t                         ctl_s3;
	logic signed [WORD_WIDTH-1:0] res_s3 [4];
	logic signed [WORD_WIDTH-1:0] res_out [4];
	logic                         derr_out;
	logic                         ovf_out;

	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	hpt_mac #(
		.FRAC_BITS  (FRAC_BITS),
		.WORD_WIDTH (WORD_WIDTH)
	) u_mac (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (en),
		.in_valid      (s_tvalid && s_tready),
		.cmd           (cmd_t'(s_tuser)),
		.row_index     (s_tdata[1:0]),
		.col_index     (s_tdata[3:2]),
		.element_value (s_tdata[35:4]),
		.in_x          (s_tdata[67:36]),
		.in_y          (s_tdata[99:68]),
		.in_z          (s_tdata[131:100]),
		.in_w          (s_tdata[163:132]),
		.valid_s3      (valid_s3),
		.ctl_s3        (ctl_s3),
		.res_s3        (res_s3)
	);

	hpt_div #(
		.FRAC_BITS  (FRAC_BITS),
		.WORD_WIDTH (WORD_WIDTH)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.valid_in  (valid_s3),
		.ctl_in    (ctl_s3),
		.res_in    (res_s3),
		.valid_out (m_tvalid),
		.derr_out  (derr_out),
		.ovf_out   (ovf_out),
		.res_out   (res_out)
	);

	assign m_tdata = {DATA_W'(res_out[3]), DATA_W'(res_out[2]),
		DATA_W'(res_out[1]), DATA_W'(res_out[0])};
	assign m_tuser = {ovf_out, derr_out};

endmodule
`default_nettype wire

// ----- verif/homogeneous_point_transform_test.sv -----
`timescale 1ns / 1ps
module homogeneous_point_transform_test;
	import hpt_pkg::*;

	localparam int FB = FRAC_BITS_DEF;
	localparam longint ONE = 64'sd1 << FB;
	localparam longint WMAX = 64'sd2147483647;
	localparam longint WMIN = -64'sd2147483648;
	localparam int LIMIT = 400000;

	typedef struct {
		logic [1:0]         row;
		logic [1:0]         col;
		logic signed [31:0] elem;
		logic signed [31:0] x, y, z, w;
	} vertex_in_t;

	typedef struct {
		logic signed [31:0] x, y, z, w;
		logic               derr;
		logic               ovf;
	} vertex_out_t;

	typedef struct {
		cmd_t        op;
		vertex_in_t  d;
		bit          typed;
		vertex_out_t res;
	} stim_row_t;

	logic                   clk = 0;
	logic                   arst_n = 0;
	logic                   s_tvalid = 0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;
	logic [1:0]             s_tuser = CMD_LOAD;
	logic                   m_tvalid;
	logic                   m_tready = 0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic [1:0]             m_tuser;

	logic signed [31:0] matrix [16];
	vertex_out_t        pending [$];
	stim_row_t          directed [$];
	int                 errors = 0;
	int                 cycles = 0;
	int                 n_results = 0, n_derr = 0, n_ovf = 0, n_loads = 0;

	homogeneous_point_transform DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("%0t timeout, %0d results outstanding", $time, pending.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	function automatic longint clamp(longint v, inout bit ovf);
		if (v > WMAX) begin
			ovf = 1;
			return WMAX;
		end
		if (v < WMIN) begin
			ovf = 1;
			return WMIN;
		end
		return v;
	endfunction

	function automatic longint fixed_quotient(longint n, longint d, inout bit ovf);
		bit neg;
		longint unsigned un, ud, q, r, cap;
		longint s;
		neg = (n < 0) != (d < 0);
		un = n < 0 ? -n : n;
		ud = d < 0 ? -d : d;
		cap = 64'd1 << 32;
		q = un / ud;
		r = un % ud;
		if (q > cap) q = cap;
		for (int i = 0; i < FB; i++) begin
			r = r << 1;
			q = q << 1;
			if (r >= ud) begin
				r = r - ud;
				q = q | 1;
			end
			if (q > cap) q = cap;
		end
		s = neg ? -longint'(q) : longint'(q);
		return clamp(s, ovf);
	endfunction

	task automatic reset_matrix();
		for (int i = 0; i < 16; i++)
			matrix[i] = (i % 5 == 0) ? 32'(ONE) : 32'sd0;
	endtask

	// Applies one accepted transaction; returns 1 when a result follows.
	function automatic bit transform(cmd_t op, vertex_in_t d, output vertex_out_t o);
		longint v [4];
		longint res [4];
		longint acc;
		bit ovf;
		ovf = 0;
		o = '{default: 0};
		if (op == CMD_LOAD) begin
			matrix[{d.row, d.col}] = d.elem;
			return 0;
		end
		v[0] = d.x;
		v[1] = d.y;
		v[2] = d.z;
		v[3] = op == CMD_POINT ? ONE : op == CMD_WPOINT ? longint'(d.w) : 0;
		for (int r = 0; r < 4; r++) begin
			acc = 0;
			for (int c = 0; c < 4; c++)
				acc += (longint'(matrix[r*4+c]) * v[c]) >>> FB;
			res[r] = clamp(acc, ovf);
		end
		if (op == CMD_VECTOR) res[3] = 0;
		if (op == CMD_POINT) begin
			if (res[3] == 0) begin
				o.derr = 1;
				ovf = 0;
				res[0] = 0;
				res[1] = 0;
				res[2] = 0;
			end else begin
				for (int r = 0; r < 3; r++)
					res[r] = fixed_quotient(res[r], res[3], ovf);
			end
		end
		o.x = res[0];
		o.y = res[1];
		o.z = res[2];
		o.w = res[3];
		o.ovf = ovf;
		return 1;
	endfunction

	function automatic logic signed [31:0] rnd_word();
		if ($urandom_range(0, 3) == 0) return $urandom;
		return int'($urandom_range(0, 32'h80000)) - 32'sh40000;
	endfunction

	task automatic idle_gap(input bit drive_low);
		int g;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: g = 0;
			5, 6, 7, 8:    g = $urandom_range(1, 3);
			default:       g = $urandom_range(8, 30);
		endcase
		if (g > 0 && drive_low) s_tvalid <= 0;
		repeat (g) @(posedge clk);
	endtask

	task automatic send(cmd_t op, vertex_in_t d, bit typed, vertex_out_t want);
		vertex_out_t o;
		bit rdy;
		s_tvalid <= 1;
		s_tuser  <= op;
		s_tdata  <= {4'b0, d.w, d.z, d.y, d.x, d.elem, d.col, d.row};
		forever begin
			@(negedge clk);
			rdy = s_tready;
			@(posedge clk);
			if (rdy) break;
		end
		if (transform(op, d, o)) begin
			if (typed && (o.x !== want.x || o.y !== want.y || o.z !== want.z ||
			    o.w !== want.w || o.derr !== want.derr || o.ovf !== want.ovf)) begin
				$display("%0t predictor disagrees with typed row: exp %p got %p",
					$time, want, o);
				errors++;
			end
			pending.push_back(typed ? want : o);
		end else
			n_loads++;
		idle_gap(1);
	endtask

	always @(posedge clk) begin
		if (!arst_n)
			m_tready <= 0;
		else if ($urandom_range(0, 39) == 0)
			m_tready <= 0;
		else if (!m_tready)
			m_tready <= $urandom_range(0, 7) == 0;
		else
			m_tready <= $urandom_range(0, 5) != 0;
	end

	always @(posedge clk) begin
		vertex_out_t got, exp_o;
		if (arst_n && m_tvalid && m_tready) begin
			got.x = m_tdata[31:0];
			got.y = m_tdata[63:32];
			got.z = m_tdata[95:64];
			got.w = m_tdata[127:96];
			got.derr = m_tuser[0];
			got.ovf = m_tuser[1];
			n_results++;
			n_derr += got.derr;
			n_ovf += got.ovf;
			if (pending.size() == 0) begin
				$display("%0t unexpected result transaction %p", $time, got);
				errors++;
			end else begin
				exp_o = pending.pop_front();
				if (got.x !== exp_o.x || got.y !== exp_o.y || got.z !== exp_o.z ||
				    got.w !== exp_o.w || got.derr !== exp_o.derr || got.ovf !== exp_o.ovf) begin
					$display("%0t mismatch: exp %p got %p", $time, exp_o, got);
					errors++;
				end
			end
		end
	end

	function automatic vertex_in_t vin(int row, int col, int elem, int x, int y, int z, int w);
		vertex_in_t d;
		d.row = row;
		d.col = col;
		d.elem = elem;
		d.x = x;
		d.y = y;
		d.z = z;
		d.w = w;
		return d;
	endfunction

	function automatic vertex_out_t vout(int x, int y, int z, int w, bit derr, bit ovf);
		vertex_out_t o;
		o.x = x;
		o.y = y;
		o.z = z;
		o.w = w;
		o.derr = derr;
		o.ovf = ovf;
		return o;
	endfunction

	task automatic add_row(cmd_t op, vertex_in_t d, bit typed = 0,
	                       vertex_out_t res = '{default: 0});
		stim_row_t s;
		s.op = op;
		s.d = d;
		s.typed = typed;
		s.res = res;
		directed.push_back(s);
	endtask

	initial begin
		vertex_in_t d;
		vertex_out_t none;
		cmd_t op;
		none = '{default: 0};
		reset_matrix();

		// identity after reset
		add_row(CMD_POINT, vin(0, 0, 0, 32'h10000, 32'h20000, -32'sh30000, 5), 1,
			vout(32'h10000, 32'h20000, -32'sh30000, 32'h10000, 0, 0));
		add_row(CMD_VECTOR, vin(0, 0, 0, 7, -8, 9, 1), 1, vout(7, -8, 9, 0, 0, 0));
		add_row(CMD_WPOINT, vin(0, 0, 0, 1, 2, 3, 0), 1, vout(1, 2, 3, 0, 0, 0));
		add_row(CMD_POINT, vin(0, 0, 0, 32'h7fffffff, 32'h80000000, 0, 0), 1,
			vout(32'h7fffffff, 32'h80000000, 0, 32'h10000, 0, 0));
		add_row(CMD_WPOINT, vin(0, 0, 0, 32'h7fffffff, 32'h80000000, -1, 32'h80000000));
		// zero w: divide error, all zeros
		add_row(CMD_LOAD, vin(3, 3, 0, 0, 0, 0, 0));
		add_row(CMD_POINT, vin(0, 0, 0, 32'h12345, 6, 7, 0), 1, vout(0, 0, 0, 0, 1, 0));
		add_row(CMD_VECTOR, vin(0, 0, 0, 32'h12345, 6, 7, 0));
		// extreme elements, saturating sums and quotients
		add_row(CMD_LOAD, vin(0, 0, 32'h7fffffff, 0, 0, 0, 0));
		add_row(CMD_LOAD, vin(0, 1, 32'h7fffffff, 0, 0, 0, 0));
		add_row(CMD_LOAD, vin(1, 2, 32'h80000000, 0, 0, 0, 0));
		add_row(CMD_LOAD, vin(3, 3, 1, 0, 0, 0, 0));
		add_row(CMD_POINT, vin(0, 0, 0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0));
		add_row(CMD_WPOINT, vin(0, 0, 0, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff));
		add_row(CMD_VECTOR, vin(0, 0, 0, 32'h80000000, 32'h80000000, 32'h80000000, 0));
		add_row(CMD_LOAD, vin(3, 0, 32'h80000000, 0, 0, 0, 0));
		add_row(CMD_LOAD, vin(3, 3, 32'h7fffffff, 0, 0, 0, 0));
		add_row(CMD_POINT, vin(0, 0, 0, 32'h10000, -32'sh10000, 32'h4000, 0));
		add_row(CMD_POINT, vin(0, 0, 0, -1, 1, 32'h7fffffff, 0));
		add_row(CMD_WPOINT, vin(0, 0, 0, -1, -1, -1, -1));

		arst_n = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		foreach (directed[i])
			send(directed[i].op, directed[i].d, directed[i].typed, directed[i].res);

		for (int i = 0; i < 930; i++) begin
			if (i == 400) begin
				s_tvalid <= 0;
				wait (pending.size() == 0);
				@(posedge clk);
			end
			case ($urandom_range(0, 7))
				0, 1:    op = CMD_LOAD;
				2, 3, 4: op = CMD_POINT;
				5, 6:    op = CMD_WPOINT;
				default: op = CMD_VECTOR;
			endcase
			d = vin($urandom_range(0, 3), $urandom_range(0, 3), rnd_word(),
				rnd_word(), rnd_word(), rnd_word(), rnd_word());
			// bias some loads back toward small or unit values so points stay meaningful
			if (op == CMD_LOAD && $urandom_range(0, 2) == 0)
				d.elem = $urandom_range(0, 1) ? 32'(ONE) : 32'sd0;
			if ($urandom_range(0, 19) == 0) d.w = 0;
			send(op, d, 0, none);
		end
		s_tvalid <= 0;

		wait (pending.size() == 0);
		repeat (60) @(posedge clk);

		$display("%0d results checked, %0d matrix loads, %0d divide errors, %0d saturations",
			n_results, n_loads, n_derr, n_ovf);
		$display("point, weighted point and vector transforms under random back-pressure");
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
